[design/ped_pkg.sv]
`timescale 1ns / 1ps

package ped_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // group queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // what one input byte turns into: up to three output bytes
  typedef struct packed {
    logic            last;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } grp_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_PCT,
    HS_DIGIT
  } held_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

[design/ped_front.sv]
`timescale 1ns / 1ps

module ped_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  ped_pkg::in_word_t word,
  output logic              push,
  output ped_pkg::grp_t     grp
);

  ped_pkg::held_state_t state_r, state_nxt, pre_state;
  logic [7:0] digit_r;
  logic       b_hex, b_pct;

  assign b_hex = ped_pkg::is_hex(word.in_byte);
  assign b_pct = (word.in_byte == ped_pkg::PCT_CHAR);

  // next state: pre_state ignores end of string, state_nxt applies it
  always_comb begin
    unique case (state_r)
      ped_pkg::HS_PCT:   pre_state = b_hex ? ped_pkg::HS_DIGIT :
                                     (b_pct ? ped_pkg::HS_PCT : ped_pkg::HS_IDLE);
      ped_pkg::HS_DIGIT: pre_state = (!b_hex && b_pct) ? ped_pkg::HS_PCT :
                                     ped_pkg::HS_IDLE;
      ped_pkg::HS_IDLE:  pre_state = b_pct ? ped_pkg::HS_PCT : ped_pkg::HS_IDLE;
      default:           pre_state = b_pct ? ped_pkg::HS_PCT : ped_pkg::HS_IDLE;
    endcase
    state_nxt = word.in_last ? ped_pkg::HS_IDLE : pre_state;
  end

  // outputs: the group of bytes this word produces
  always_comb begin
    grp = '0;
    grp.last = word.in_last;
    unique case (state_r)
      ped_pkg::HS_PCT: begin
        if (!b_hex) begin
          grp.bytes[0] = ped_pkg::PCT_CHAR;
          grp.bytes[1] = word.in_byte;
          grp.cnt = b_pct ? 2'd1 : 2'd2;
        end
      end
      ped_pkg::HS_DIGIT: begin
        if (b_hex) begin
          grp.bytes[0] = {ped_pkg::hex_nib(digit_r), ped_pkg::hex_nib(word.in_byte)};
          grp.cnt = 2'd1;
        end else begin
          grp.bytes[0] = ped_pkg::PCT_CHAR;
          grp.bytes[1] = digit_r;
          grp.bytes[2] = word.in_byte;
          grp.cnt = b_pct ? 2'd2 : 2'd3;
        end
      end
      default: begin
        if (!b_pct) begin
          grp.bytes[0] = word.in_byte;
          grp.cnt = 2'd1;
        end
      end
    endcase
    // end of string: flush whatever would still be held
    if (word.in_last) begin
      if (pre_state == ped_pkg::HS_PCT) begin
        grp.bytes[grp.cnt] = ped_pkg::PCT_CHAR;
        grp.cnt = grp.cnt + 2'd1;
      end else if (pre_state == ped_pkg::HS_DIGIT) begin
        grp.bytes[0] = ped_pkg::PCT_CHAR;
        grp.bytes[1] = word.in_byte;
        grp.cnt = 2'd2;
      end
    end
  end

  assign push = take && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ped_pkg::HS_IDLE;
      digit_r <= 8'h00;
    end else if (take) begin
      state_r <= state_nxt;
      if (state_nxt == ped_pkg::HS_DIGIT) begin
        digit_r <= word.in_byte;
      end
    end
  end

endmodule

[design/ped_queue.sv]
`timescale 1ns / 1ps

module ped_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ped_pkg::grp_t push_grp,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output ped_pkg::grp_t head
);

  ped_pkg::grp_t mem_r [ped_pkg::QUEUE_DEPTH];
  logic [ped_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [ped_pkg::QCNT_W-1:0] count_r;

  assign full     = (count_r == ped_pkg::QCNT_W'(ped_pkg::QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[design/ped_back.sv]
`timescale 1ns / 1ps

module ped_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  ped_pkg::grp_t      q_head,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output ped_pkg::out_word_t out_word
);

  logic [1:0]         idx_r;
  logic               out_valid_r;
  ped_pkg::out_word_t out_word_r;
  logic               load, at_end;

  assign load   = q_nonempty && (!out_valid_r || !out_stall);
  assign at_end = (idx_r == (q_head.cnt - 2'd1));
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= at_end ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r.out_byte <= q_head.bytes[idx_r];
      out_word_r.out_last <= q_head.last && at_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[design/percent_escape_decoder.sv]
`timescale 1ns / 1ps

// Percent-escape decoder. Takes one raw byte per word and writes the decoded
// bytes: '%' plus two hex digits becomes one byte, any broken escape passes
// through literally, and a word with in_last set flushes what is held and
// marks its final result with out_last. The input side takes one word per
// cycle while the queue has room; a word yields zero to three results, and
// the output side delivers one result per cycle while out_stall is low, so
// over an unstalled string the rate is one byte per cycle. Each result passes
// through a four-entry group queue and then the output register; in_stall
// rises only while that queue is full.

module percent_escape_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ped_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ped_pkg::out_word_t out_data
);

  logic          take, push, pop, q_full, q_nonempty;
  ped_pkg::grp_t grp, q_head;

  // hold the input only while the queue has no room for a group
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // front: track held '%' / digit, turn each word into a byte group
  ped_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .word  (in_data),
    .push  (push),
    .grp   (grp)
  );

  // decouple: groups wait here while the output side is stalled
  ped_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (grp),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // back: advance through the head group one byte per cycle unless out_stall holds it
  ped_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_word   (out_data)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ped_pkg::*;

  // Tracks the decoder's held bytes, predicts the decoded words each raw word
  // causes, and checks the output stream against them in order.
  class decode_tracker;
    held_state_t held;
    logic [7:0]  held_digit;
    out_word_t   decoded_due[$];
    int          mismatches;

    function new();
      held       = HS_IDLE;
      held_digit = 8'h00;
      mismatches = 0;
    endfunction

    // hex digit value, or -1 for anything else
    static function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
    endfunction

    static function out_word_t plain(logic [7:0] b);
      return '{out_byte: b, out_last: 1'b0};
    endfunction

    function void note_raw_word(in_word_t w);
      out_word_t step[$];
      int        lo;
      int        hi;
      lo = digit_value(w.in_byte);
      case (held)
        HS_PCT: begin
          if (lo >= 0) begin
            held       = HS_DIGIT;
            held_digit = w.in_byte;
          end else if (w.in_byte == PCT_CHAR) begin
            step = {step, plain(PCT_CHAR)};
          end else begin
            step = {step, plain(PCT_CHAR)};
            step = {step, plain(w.in_byte)};
            held = HS_IDLE;
          end
        end
        HS_DIGIT: begin
          if (lo >= 0) begin
            hi = digit_value(held_digit);
            step = {step, plain(8'(hi * 16 + lo))};
            held = HS_IDLE;
          end else begin
            step = {step, plain(PCT_CHAR)};
            step = {step, plain(held_digit)};
            if (w.in_byte == PCT_CHAR) begin
              held = HS_PCT;
            end else begin
              step = {step, plain(w.in_byte)};
              held = HS_IDLE;
            end
          end
        end
        default: begin
          if (w.in_byte == PCT_CHAR) begin
            held = HS_PCT;
          end else begin
            step = {step, plain(w.in_byte)};
            held = HS_IDLE;
          end
        end
      endcase
      if (w.in_last) begin
        if (held == HS_PCT) begin
          step = {step, plain(PCT_CHAR)};
        end else if (held == HS_DIGIT) begin
          step = {step, plain(PCT_CHAR)};
          step = {step, plain(held_digit)};
        end
        held       = HS_IDLE;
        held_digit = 8'h00;
        if (step.size() > 0) step[step.size() - 1].out_last = 1'b1;
      end
      decoded_due = {decoded_due, step};
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 60) $display("mismatch: %s", what);
    endtask

    task check_decoded_word(out_word_t got);
      out_word_t want;
      if (decoded_due.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.out_last));
      end else begin
        want = decoded_due.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
          report($sformatf("last %0b on byte %02h, want %0b",
                           got.out_last, got.out_byte, want.out_last));
      end
    endtask
  endclass

  localparam int LIMIT_CYCLES = 200000;
  localparam int RAW_TARGET   = 460;
  localparam int HOLD_CYCLES  = 300;
  localparam string HEX_CHARS = "0123456789ABCDEFabcdef";

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;

  decode_tracker tracker = new();

  int snd_pct  = 30;
  int rcv_pct  = 83;
  int raw_sent = 0;
  int cycles   = 0;
  bit hold_req = 1'b0;

  percent_escape_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run counter: end the run with a failure if it drags past the limit.
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Offer one raw word, idling first at the current rate, then hold it until
  // the decoder takes it and note it in the tracker.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_raw_word(w);
    raw_sent++;
  endtask

  // Send a text as one string; mark its final character as the end.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_word('{in_byte: s[i], in_last: (i == s.len() - 1)});
  endtask

  function automatic logic [7:0] any_hex();
    return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
  endfunction

  // Build a string with proper escapes as its most common piece, and plain bytes,
  // lone '%', broken escapes, field extremes and bytes next to the hex ranges.
  task automatic send_random_string();
    logic [7:0] s[$];
    logic [7:0] edges[8];
    int         pieces;
    edges  = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          s = {s, PCT_CHAR};
          s = {s, any_hex()};
          s = {s, any_hex()};
        end
        4, 5: s = {s, 8'($urandom_range(255))};
        6:    s = {s, PCT_CHAR};
        7: begin
          s = {s, PCT_CHAR};
          s = {s, any_hex()};
          s = {s, 8'($urandom_range(255))};
        end
        8: begin
          s = {s, PCT_CHAR};
          s = {s, 8'($urandom_range(255))};
        end
        default: s = {s, edges[$urandom_range(7)]};
      endcase
    end
    foreach (s[i]) send_word('{in_byte: s[i], in_last: (i == s.size() - 1)});
  endtask

  // Output side: stall at the current rate, or hold off for a long stretch
  // when asked, and check every word taken.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      if (hold_req && hold_left == 0) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_pct);
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.check_decoded_word(out_data);
    end
  end

  initial begin
    // hold reset low, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: field extremes, decoded escapes in both cases,
    // non-hex after '%', digit then non-hex, '%' after a held digit,
    // doubled '%', and flushes of '%' and '%'+digit at end of string.
    send_word('{in_byte: 8'h00, in_last: 1'b0});
    send_word('{in_byte: 8'hFF, in_last: 1'b1});
    send_text("%aF");
    send_text("%09%%");
    send_text("%G");
    send_text("%fz");
    send_text("%1%F");
    send_text("%");
    send_word('{in_byte: PCT_CHAR, in_last: 1'b0});
    send_word('{in_byte: 8'hFF, in_last: 1'b1});
    send_text("%B0");
    send_text("%4");

    // Random strings in three idling phases; start the phase without idling
    // with a long output hold-off so the decoder fills and stalls its input.
    while (raw_sent < RAW_TARGET) begin
      if (raw_sent >= 300 && snd_pct != 0) begin
        snd_pct  = 0;
        rcv_pct  = 0;
        hold_req = 1'b1;
      end else if (raw_sent >= 150 && raw_sent < 300 && snd_pct != 83) begin
        snd_pct = 83;
        rcv_pct = 30;
      end
      send_random_string();
    end
    in_valid <= 1'b0;

    // drain the expected bytes, then let the decoder idle before the verdict
    while (tracker.decoded_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
